// File: rtl/core/jsu_pkg.sv
// Package for the JSON string unescaper: decode modes, status codes,
// byte counts and the result record. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    typedef enum logic [2:0] {
        MODE_WAIT    = 3'd0,
        MODE_STRING  = 3'd1,
        MODE_ESCAPE  = 3'd2,
        MODE_HEX_HI  = 3'd3,
        MODE_WANT_BS = 3'd4,
        MODE_WANT_U  = 3'd5,
        MODE_HEX_LO  = 3'd6
    } mode_t;

    typedef enum logic [3:0] {
        ST_BUSY     = 4'd0,
        ST_DONE     = 4'd1,
        ST_NOQUOTE  = 4'd2,
        ST_CONTROL  = 4'd3,
        ST_BADESC   = 4'd4,
        ST_BADHEX   = 4'd5,
        ST_LONEHIGH = 4'd6,
        ST_LONELOW  = 4'd7,
        ST_EARLYEND = 4'd8
    } status_t;

    localparam logic [2:0] CNT_0 = 3'd0;
    localparam logic [2:0] CNT_1 = 3'd1;
    localparam logic [2:0] CNT_2 = 3'd2;
    localparam logic [2:0] CNT_3 = 3'd3;
    localparam logic [2:0] CNT_4 = 3'd4;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_U = 8'h75;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [15:0] SURR_HI_LO = 16'hD800;
    localparam logic [15:0] SURR_HI_HI = 16'hDBFF;
    localparam logic [15:0] SURR_LO_LO = 16'hDC00;
    localparam logic [15:0] SURR_LO_HI = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    typedef struct packed {
        logic [31:0] bytes;
        logic [2:0]  count;
        status_t     status;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/jsu_utf8_enc.sv
// UTF-8 encoder: one code point in, 1 to 4 packed bytes and a count out.
// Purely combinational; uses jsu_pkg for count constants.
`timescale 1ns / 1ps
`default_nettype none

module jsu_utf8_enc (
    input  wire logic [20:0] cp_in,
    output logic      [31:0] utf8_bytes,
    output logic      [2:0]  byte_count
);

    always_comb begin
        if (cp_in <= 21'h7F) begin
            utf8_bytes = {24'd0, cp_in[7:0]};
            byte_count = jsu_pkg::CNT_1;
        end else if (cp_in <= 21'h7FF) begin
            utf8_bytes = {16'd0, 2'b10, cp_in[5:0], 3'b110, cp_in[10:6]};
            byte_count = jsu_pkg::CNT_2;
        end else if (cp_in <= 21'hFFFF) begin
            utf8_bytes = {8'd0, 2'b10, cp_in[5:0], 2'b10, cp_in[11:6],
                          4'b1110, cp_in[15:12]};
            byte_count = jsu_pkg::CNT_3;
        end else begin
            utf8_bytes = {2'b10, cp_in[5:0], 2'b10, cp_in[11:6],
                          2'b10, cp_in[17:12], 5'b11110, cp_in[20:18]};
            byte_count = jsu_pkg::CNT_4;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/json_string_unescape_utf8.sv
// Top level of the JSON string unescaper: decode state, result register
// and skid register. Depends on jsu_pkg and jsu_utf8_enc.
`timescale 1ns / 1ps
`default_nettype none

// One input transaction carries one byte of JSON text (or an end-of-text
// mark) and yields exactly one result transaction: up to four UTF-8 bytes,
// packed first byte lowest, a byte count and a status. The block takes one
// byte per cycle while s_ready is high; the decode state is updated in the
// cycle the byte is accepted and the result is registered for the m_ side.
// A result register backed by a one-entry skid register holds results while
// the consumer stalls, so s_ready drops only when both are full. Any error
// or a closing quote returns the decoder to waiting for an opening quote.
module json_string_unescape_utf8 (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    input  wire logic        s_end_of_text,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic      [31:0] m_utf8_bytes,
    output logic      [2:0]  m_byte_count,
    output logic      [3:0]  m_status
);

    jsu_pkg::mode_t   mode_reg, mode_next;
    logic [1:0]       hex_cnt_reg, hex_cnt_next;
    logic [15:0]      hex_acc_reg, hex_acc_next;
    logic [9:0]       hs_bits_reg, hs_bits_next;

    jsu_pkg::result_t res_new;
    jsu_pkg::result_t out_reg, skid_reg;
    logic             out_valid_reg, skid_valid_reg;

    logic             push, pop;
    logic [3:0]       hex_val;
    logic             hex_ok;
    logic [15:0]      acc_shift;
    logic [20:0]      enc_cp;
    logic [31:0]      enc_bytes;
    logic [2:0]       enc_count;

    assign s_ready = !skid_valid_reg;
    assign push    = s_valid && s_ready;
    assign pop     = out_valid_reg && m_ready;

    // hex digit value
    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        case (s_in_byte) inside
            [8'h30:8'h39]: hex_val = 4'(s_in_byte - 8'h30);
            [8'h61:8'h66]: hex_val = 4'(s_in_byte - 8'h57);
            [8'h41:8'h46]: hex_val = 4'(s_in_byte - 8'h37);
            default:       hex_ok  = 1'b0;
        endcase
    end

    assign acc_shift = {hex_acc_reg[11:0], hex_val};

    // second escape of a pair always lies in DC00..DFFF when it is encoded
    assign enc_cp = (mode_reg == jsu_pkg::MODE_HEX_LO)
                  ? jsu_pkg::SUPP_BASE + {1'b0, hs_bits_reg, 10'd0} + {11'd0, acc_shift[9:0]}
                  : {5'd0, acc_shift};

    jsu_utf8_enc u_enc (
        .cp_in      (enc_cp),
        .utf8_bytes (enc_bytes),
        .byte_count (enc_count)
    );

    // next decode state
    always_comb begin
        mode_next    = mode_reg;
        hex_cnt_next = hex_cnt_reg;
        hex_acc_next = hex_acc_reg;
        hs_bits_next = hs_bits_reg;
        res_new.bytes  = 32'd0;
        res_new.count  = jsu_pkg::CNT_0;
        res_new.status = jsu_pkg::ST_BUSY;

        case (mode_reg)
            jsu_pkg::MODE_STRING: begin
                if (s_end_of_text) begin
                    res_new.status = jsu_pkg::ST_EARLYEND;
                    mode_next = jsu_pkg::MODE_WAIT;
                end else if (s_in_byte == jsu_pkg::CH_QUOTE) begin
                    res_new.status = jsu_pkg::ST_DONE;
                    mode_next = jsu_pkg::MODE_WAIT;
                end else if (s_in_byte < jsu_pkg::CH_SPACE) begin
                    res_new.status = jsu_pkg::ST_CONTROL;
                    mode_next = jsu_pkg::MODE_WAIT;
                end else if (s_in_byte == jsu_pkg::CH_BSLASH) begin
                    mode_next = jsu_pkg::MODE_ESCAPE;
                end else begin
                    res_new.bytes = {24'd0, s_in_byte};
                    res_new.count = jsu_pkg::CNT_1;
                end
            end
            jsu_pkg::MODE_ESCAPE: begin
                if (s_end_of_text) begin
                    res_new.status = jsu_pkg::ST_EARLYEND;
                    mode_next = jsu_pkg::MODE_WAIT;
                end else begin
                    mode_next     = jsu_pkg::MODE_STRING;
                    res_new.count = jsu_pkg::CNT_1;
                    case (s_in_byte)
                        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
                            res_new.bytes = {24'd0, s_in_byte};
                        8'h62: res_new.bytes = 32'h08;
                        8'h66: res_new.bytes = 32'h0C;
                        8'h6E: res_new.bytes = 32'h0A;
                        8'h72: res_new.bytes = 32'h0D;
                        8'h74: res_new.bytes = 32'h09;
                        jsu_pkg::CH_U: begin
                            res_new.count = jsu_pkg::CNT_0;
                            mode_next     = jsu_pkg::MODE_HEX_HI;
                            hex_cnt_next  = 2'd0;
                            hex_acc_next  = 16'd0;
                        end
                        default: begin
                            res_new.count  = jsu_pkg::CNT_0;
                            res_new.status = jsu_pkg::ST_BADESC;
                            mode_next      = jsu_pkg::MODE_WAIT;
                        end
                    endcase
                end
            end
            jsu_pkg::MODE_HEX_HI, jsu_pkg::MODE_HEX_LO: begin
                if (s_end_of_text) begin
                    res_new.status = jsu_pkg::ST_EARLYEND;
                    mode_next = jsu_pkg::MODE_WAIT;
                end else if (!hex_ok) begin
                    res_new.status = jsu_pkg::ST_BADHEX;
                    mode_next = jsu_pkg::MODE_WAIT;
                end else if (hex_cnt_reg != 2'd3) begin
                    hex_acc_next = acc_shift;
                    hex_cnt_next = hex_cnt_reg + 2'd1;
                end else begin
                    hex_acc_next = acc_shift;
                    hex_cnt_next = 2'd0;
                    if (mode_reg == jsu_pkg::MODE_HEX_HI) begin
                        if (acc_shift >= jsu_pkg::SURR_HI_LO
                            && acc_shift <= jsu_pkg::SURR_HI_HI) begin
                            hs_bits_next = acc_shift[9:0];
                            mode_next    = jsu_pkg::MODE_WANT_BS;
                        end else if (acc_shift >= jsu_pkg::SURR_LO_LO
                                     && acc_shift <= jsu_pkg::SURR_LO_HI) begin
                            res_new.status = jsu_pkg::ST_LONELOW;
                            mode_next = jsu_pkg::MODE_WAIT;
                        end else begin
                            res_new.bytes = enc_bytes;
                            res_new.count = enc_count;
                            hex_acc_next  = 16'd0;
                            mode_next     = jsu_pkg::MODE_STRING;
                        end
                    end else begin
                        if (acc_shift < jsu_pkg::SURR_LO_LO
                            || acc_shift > jsu_pkg::SURR_LO_HI) begin
                            res_new.status = jsu_pkg::ST_LONEHIGH;
                            mode_next = jsu_pkg::MODE_WAIT;
                        end else begin
                            res_new.bytes = enc_bytes;
                            res_new.count = enc_count;
                            hex_acc_next  = 16'd0;
                            hs_bits_next  = 10'd0;
                            mode_next     = jsu_pkg::MODE_STRING;
                        end
                    end
                end
            end
            jsu_pkg::MODE_WANT_BS: begin
                if (!s_end_of_text && s_in_byte == jsu_pkg::CH_BSLASH) begin
                    mode_next = jsu_pkg::MODE_WANT_U;
                end else begin
                    res_new.status = jsu_pkg::ST_LONEHIGH;
                    mode_next = jsu_pkg::MODE_WAIT;
                end
            end
            jsu_pkg::MODE_WANT_U: begin
                if (!s_end_of_text && s_in_byte == jsu_pkg::CH_U) begin
                    mode_next    = jsu_pkg::MODE_HEX_LO;
                    hex_cnt_next = 2'd0;
                    hex_acc_next = 16'd0;
                end else begin
                    res_new.status = jsu_pkg::ST_LONEHIGH;
                    mode_next = jsu_pkg::MODE_WAIT;
                end
            end
            default: begin
                // waiting for the opening quote; unused codes land here too
                if (!s_end_of_text && s_in_byte == jsu_pkg::CH_QUOTE) begin
                    mode_next = jsu_pkg::MODE_STRING;
                end else begin
                    res_new.status = jsu_pkg::ST_NOQUOTE;
                    mode_next = jsu_pkg::MODE_WAIT;
                end
            end
        endcase

        // any return to waiting clears the escape state
        if (mode_next == jsu_pkg::MODE_WAIT || mode_reg == jsu_pkg::MODE_WAIT) begin
            hex_cnt_next = 2'd0;
            hex_acc_next = 16'd0;
            hs_bits_next = 10'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= jsu_pkg::MODE_WAIT;
            hex_cnt_reg <= 2'd0;
            hex_acc_reg <= 16'd0;
            hs_bits_reg <= 10'd0;
        end else if (push) begin
            mode_reg    <= mode_next;
            hex_cnt_reg <= hex_cnt_next;
            hex_acc_reg <= hex_acc_next;
            hs_bits_reg <= hs_bits_next;
        end
    end

    // result register with skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop) begin
            if (skid_valid_reg) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end else if (push) begin
                out_reg <= res_new;
            end else begin
                out_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!out_valid_reg) begin
                out_reg       <= res_new;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= res_new;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_utf8_bytes = out_reg.bytes;
    assign m_byte_count = out_reg.count;
    assign m_status     = out_reg.status;

endmodule

`default_nettype wire

// File: verif/tb.sv
// Self-checking testbench for json_string_unescape_utf8: a queue-fed driver
// and a monitor with random gaps, checked against an in-bench decoder model.
// Depends on jsu_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb;

    localparam int RANDOM_ITEMS = 1650;
    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 10;

    localparam logic [7:0] CH_B = 8'h62;
    localparam logic [7:0] CH_F = 8'h66;
    localparam logic [7:0] CH_N = 8'h6E;
    localparam logic [7:0] CH_R = 8'h72;
    localparam logic [7:0] CH_T = 8'h74;
    localparam logic [7:0] CH_X = 8'h78;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;
    localparam logic [7:0] CH_LC_A = 8'h61;
    localparam logic [7:0] CH_LC_F = 8'h66;
    localparam logic [7:0] CH_UC_A = 8'h41;
    localparam logic [7:0] CH_UC_F = 8'h46;

    typedef struct {
        logic [7:0] data;
        logic       eot;
    } text_item_t;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'h00;
    logic        s_end_of_text = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_utf8_bytes;
    logic [2:0]  m_byte_count;
    logic [3:0]  m_status;

    json_string_unescape_utf8 u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_end_of_text (s_end_of_text),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_utf8_bytes  (m_utf8_bytes),
        .m_byte_count  (m_byte_count),
        .m_status      (m_status)
    );

    text_item_t       text_q[$];
    jsu_pkg::result_t utf8_expect_q[$];
    int               err_count = 0;

    // decoder model state
    jsu_pkg::mode_t dec_mode;
    logic [1:0]     dig_cnt;
    logic [15:0]    hex_acc;
    logic [9:0]     hi_bits;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
        if (c >= CH_LC_A && c <= CH_LC_F) return int'(c - CH_LC_A) + 10;
        if (c >= CH_UC_A && c <= CH_UC_F) return int'(c - CH_UC_A) + 10;
        return -1;
    endfunction

    function automatic void utf8_pack(input logic [20:0] cp, output logic [31:0] b,
                                      output logic [2:0] n);
        if (cp <= 21'h7F) begin
            n = jsu_pkg::CNT_1;
            b = {24'h0, cp[7:0]};
        end else if (cp <= 21'h7FF) begin
            n = jsu_pkg::CNT_2;
            b = {16'h0, 2'b10, cp[5:0], 3'b110, cp[10:6]};
        end else if (cp <= 21'hFFFF) begin
            n = jsu_pkg::CNT_3;
            b = {8'h0, 2'b10, cp[5:0], 2'b10, cp[11:6], 4'b1110, cp[15:12]};
        end else begin
            n = jsu_pkg::CNT_4;
            b = {2'b10, cp[5:0], 2'b10, cp[11:6], 2'b10, cp[17:12], 5'b11110, cp[20:18]};
        end
    endfunction

    function void to_idle();
        dec_mode = jsu_pkg::MODE_WAIT;
        dig_cnt = 2'd0;
        hex_acc = 16'h0;
        hi_bits = 10'h0;
    endfunction

    // advance the decoder model by one byte and queue the result it gives
    function void decode_byte(input logic [7:0] b, input logic eot);
        jsu_pkg::result_t r;
        int               hv;
        logic [20:0]      cp;
        r.bytes = 32'h0;
        r.count = jsu_pkg::CNT_0;
        r.status = jsu_pkg::ST_BUSY;
        case (dec_mode)
            jsu_pkg::MODE_STRING: begin
                if (eot) begin
                    r.status = jsu_pkg::ST_EARLYEND;
                    to_idle();
                end else if (b == jsu_pkg::CH_QUOTE) begin
                    r.status = jsu_pkg::ST_DONE;
                    to_idle();
                end else if (b < jsu_pkg::CH_SPACE) begin
                    r.status = jsu_pkg::ST_CONTROL;
                    to_idle();
                end else if (b == jsu_pkg::CH_BSLASH) begin
                    dec_mode = jsu_pkg::MODE_ESCAPE;
                end else begin
                    r.bytes = {24'h0, b};
                    r.count = jsu_pkg::CNT_1;
                end
            end
            jsu_pkg::MODE_ESCAPE: begin
                if (eot) begin
                    r.status = jsu_pkg::ST_EARLYEND;
                    to_idle();
                end else begin
                    r.count = jsu_pkg::CNT_1;
                    dec_mode = jsu_pkg::MODE_STRING;
                    case (b)
                        jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
                            r.bytes = {24'h0, b};
                        CH_B: r.bytes = 32'h08;
                        CH_F: r.bytes = 32'h0C;
                        CH_N: r.bytes = 32'h0A;
                        CH_R: r.bytes = 32'h0D;
                        CH_T: r.bytes = 32'h09;
                        jsu_pkg::CH_U: begin
                            r.count = jsu_pkg::CNT_0;
                            dec_mode = jsu_pkg::MODE_HEX_HI;
                            dig_cnt = 2'd0;
                            hex_acc = 16'h0;
                        end
                        default: begin
                            r.count = jsu_pkg::CNT_0;
                            r.status = jsu_pkg::ST_BADESC;
                            to_idle();
                        end
                    endcase
                end
            end
            jsu_pkg::MODE_HEX_HI, jsu_pkg::MODE_HEX_LO: begin
                hv = hex_nibble(b);
                if (eot) begin
                    r.status = jsu_pkg::ST_EARLYEND;
                    to_idle();
                end else if (hv < 0) begin
                    r.status = jsu_pkg::ST_BADHEX;
                    to_idle();
                end else begin
                    hex_acc = {hex_acc[11:0], hv[3:0]};
                    if (dig_cnt != 2'd3) begin
                        dig_cnt = dig_cnt + 2'd1;
                    end else begin
                        dig_cnt = 2'd0;
                        if (dec_mode == jsu_pkg::MODE_HEX_HI) begin
                            if (hex_acc >= jsu_pkg::SURR_HI_LO
                                && hex_acc <= jsu_pkg::SURR_HI_HI) begin
                                hi_bits = hex_acc[9:0];
                                dec_mode = jsu_pkg::MODE_WANT_BS;
                            end else if (hex_acc >= jsu_pkg::SURR_LO_LO
                                         && hex_acc <= jsu_pkg::SURR_LO_HI) begin
                                r.status = jsu_pkg::ST_LONELOW;
                                to_idle();
                            end else begin
                                utf8_pack({5'h0, hex_acc}, r.bytes, r.count);
                                hex_acc = 16'h0;
                                dec_mode = jsu_pkg::MODE_STRING;
                            end
                        end else begin
                            if (hex_acc < jsu_pkg::SURR_LO_LO
                                || hex_acc > jsu_pkg::SURR_LO_HI) begin
                                r.status = jsu_pkg::ST_LONEHIGH;
                                to_idle();
                            end else begin
                                cp = jsu_pkg::SUPP_BASE + {1'b0, hi_bits, hex_acc[9:0]};
                                utf8_pack(cp, r.bytes, r.count);
                                hex_acc = 16'h0;
                                hi_bits = 10'h0;
                                dec_mode = jsu_pkg::MODE_STRING;
                            end
                        end
                    end
                end
            end
            jsu_pkg::MODE_WANT_BS: begin
                if (!eot && b == jsu_pkg::CH_BSLASH) begin
                    dec_mode = jsu_pkg::MODE_WANT_U;
                end else begin
                    r.status = jsu_pkg::ST_LONEHIGH;
                    to_idle();
                end
            end
            jsu_pkg::MODE_WANT_U: begin
                if (!eot && b == jsu_pkg::CH_U) begin
                    dec_mode = jsu_pkg::MODE_HEX_LO;
                    dig_cnt = 2'd0;
                    hex_acc = 16'h0;
                end else begin
                    r.status = jsu_pkg::ST_LONEHIGH;
                    to_idle();
                end
            end
            default: begin
                if (!eot && b == jsu_pkg::CH_QUOTE) begin
                    to_idle();
                    dec_mode = jsu_pkg::MODE_STRING;
                end else begin
                    r.status = jsu_pkg::ST_NOQUOTE;
                    to_idle();
                end
            end
        endcase
        utf8_expect_q.insert(utf8_expect_q.size(), r);
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [15:0] rand_in(input logic [15:0] lo, input logic [15:0] hi);
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return lo;
        if (r == 1) return hi;
        return 16'($urandom_range(int'(lo), int'(hi)));
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return CH_ZERO + {4'h0, n};
        if ($urandom_range(0, 1) == 0) return CH_LC_A + {4'h0, n} - 8'd10;
        return CH_UC_A + {4'h0, n} - 8'd10;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        text_item_t it;
        it.data = b;
        it.eot = 1'b0;
        text_q.insert(text_q.size(), it);
    endtask

    // end of text; the data byte is don't-care and randomized
    task automatic push_eot();
        text_item_t it;
        it.data = 8'($urandom_range(0, 255));
        it.eot = 1'b1;
        text_q.insert(text_q.size(), it);
    endtask

    task automatic push_hex_digits(input int k);
        for (int j = 0; j < k; j++) push_byte(hex_char(4'($urandom_range(0, 15))));
    endtask

    task automatic push_u(input logic [15:0] v);
        push_byte(jsu_pkg::CH_BSLASH);
        push_byte(jsu_pkg::CH_U);
        for (int j = 3; j >= 0; j--) push_byte(hex_char(v[j*4 +: 4]));
    endtask

    function automatic logic [15:0] rand_high();
        return rand_in(jsu_pkg::SURR_HI_LO, jsu_pkg::SURR_HI_HI);
    endfunction

    function automatic logic [15:0] rand_not_low();
        if ($urandom_range(0, 1) == 0) return rand_in(16'h0000, jsu_pkg::SURR_HI_HI);
        return rand_in(16'hE000, 16'hFFFF);
    endfunction

    function automatic logic [15:0] rand_bmp();
        case ($urandom_range(0, 3))
            0: return rand_in(16'h0000, 16'h007F);
            1: return rand_in(16'h0080, 16'h07FF);
            2: return rand_in(16'h0800, 16'hD7FF);
            default: return rand_in(16'hE000, 16'hFFFF);
        endcase
    endfunction

    task automatic push_fault();
        logic [7:0] b;
        case ($urandom_range(0, 8))
            0: push_byte(8'(rand_in(16'h00, 16'h1F)));
            1: begin
                do b = 8'($urandom_range(0, 255));
                while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH ||
                       b == jsu_pkg::CH_SLASH || b == CH_B || b == CH_F || b == CH_N ||
                       b == CH_R || b == CH_T || b == jsu_pkg::CH_U);
                push_byte(jsu_pkg::CH_BSLASH);
                push_byte(b);
            end
            2: begin
                do b = 8'($urandom_range(0, 255));
                while (hex_nibble(b) >= 0);
                if ($urandom_range(0, 1) == 0) push_u(rand_high());
                push_byte(jsu_pkg::CH_BSLASH);
                push_byte(jsu_pkg::CH_U);
                push_hex_digits($urandom_range(0, 3));
                push_byte(b);
            end
            3: push_u(rand_in(jsu_pkg::SURR_LO_LO, jsu_pkg::SURR_LO_HI));
            4: begin
                push_u(rand_high());
                push_eot();
            end
            5: begin
                push_u(rand_high());
                do b = 8'($urandom_range(0, 255));
                while (b == jsu_pkg::CH_BSLASH);
                push_byte(b);
            end
            6: begin
                push_u(rand_high());
                push_byte(jsu_pkg::CH_BSLASH);
                if ($urandom_range(0, 3) == 0) begin
                    push_eot();
                end else begin
                    do b = 8'($urandom_range(0, 255));
                    while (b == jsu_pkg::CH_U);
                    push_byte(b);
                end
            end
            7: begin
                push_u(rand_high());
                push_u(rand_not_low());
            end
            default: begin
                // text ends somewhere inside the literal
                case ($urandom_range(0, 3))
                    0: ;
                    1: push_byte(jsu_pkg::CH_BSLASH);
                    2: begin
                        push_byte(jsu_pkg::CH_BSLASH);
                        push_byte(jsu_pkg::CH_U);
                        push_hex_digits($urandom_range(0, 3));
                    end
                    default: begin
                        push_u(rand_high());
                        push_byte(jsu_pkg::CH_BSLASH);
                        push_byte(jsu_pkg::CH_U);
                        push_hex_digits($urandom_range(0, 3));
                    end
                endcase
                push_eot();
            end
        endcase
    endtask

    task automatic push_literal();
        int         ntok;
        int         kind;
        bit         broken;
        logic [7:0] b;
        if ($urandom_range(0, 9) == 0) begin
            // noise between literals
            if ($urandom_range(0, 3) == 0) push_eot();
            else push_byte(8'($urandom_range(0, 255)));
            return;
        end
        push_byte(jsu_pkg::CH_QUOTE);
        ntok = $urandom_range(0, 10);
        broken = 1'b0;
        for (int i = 0; i < ntok && !broken; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                do b = 8'($urandom_range(32, 255));
                while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
                push_byte(b);
            end else if (kind < 55) begin
                push_byte(jsu_pkg::CH_BSLASH);
                case ($urandom_range(0, 7))
                    0: push_byte(jsu_pkg::CH_QUOTE);
                    1: push_byte(jsu_pkg::CH_BSLASH);
                    2: push_byte(jsu_pkg::CH_SLASH);
                    3: push_byte(CH_B);
                    4: push_byte(CH_F);
                    5: push_byte(CH_N);
                    6: push_byte(CH_R);
                    default: push_byte(CH_T);
                endcase
            end else if (kind < 75) begin
                push_u(rand_bmp());
            end else if (kind < 88) begin
                push_u(rand_high());
                push_u(rand_in(jsu_pkg::SURR_LO_LO, jsu_pkg::SURR_LO_HI));
            end else begin
                push_fault();
                broken = 1'b1;
            end
        end
        if (!broken) begin
            if ($urandom_range(0, 19) == 0) push_eot();
            else push_byte(jsu_pkg::CH_QUOTE);
        end
    endtask

    // ---------------- driver ----------------

    int         gap_left = 0;
    int         calm_s = 0;
    text_item_t cur_item;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_in_byte <= 8'h00;
            s_end_of_text <= 1'b0;
            gap_left = 0;
            to_idle();
        end else begin
            if (s_valid && s_ready) decode_byte(s_in_byte, s_end_of_text);
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (text_q.size() != 0) begin
                    cur_item = text_q.pop_front();
                    s_valid <= 1'b1;
                    s_in_byte <= cur_item.data;
                    s_end_of_text <= cur_item.eot;
                    if (calm_s > 0) begin
                        calm_s--;
                        gap_left = 0;
                    end else begin
                        gap_left = pick_gap();
                        if ($urandom_range(0, 49) == 0) calm_s = $urandom_range(20, 80);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------

    int               stall_left = 0;
    int               calm_m = 0;
    jsu_pkg::result_t want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (utf8_expect_q.size() == 0) begin
                    $display("%0t: unexpected result: bytes %h count %0d status %0d",
                             $time, m_utf8_bytes, m_byte_count, m_status);
                    err_count++;
                end else begin
                    want = utf8_expect_q.pop_front();
                    if (m_utf8_bytes !== want.bytes) begin
                        $display("%0t: utf8_bytes expected %h actual %h",
                                 $time, want.bytes, m_utf8_bytes);
                        err_count++;
                    end
                    if (m_byte_count !== want.count) begin
                        $display("%0t: byte_count expected %0d actual %0d",
                                 $time, want.count, m_byte_count);
                        err_count++;
                    end
                    if (m_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_status);
                        err_count++;
                    end
                end
            end
            if (stall_left == 0 && calm_m == 0 && $urandom_range(0, 3) == 0)
                stall_left = pick_gap();
            if (calm_m > 0) calm_m--;
            else if ($urandom_range(0, 49) == 0) calm_m = $urandom_range(20, 80);
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------- watchdog ----------------

    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("tb NOT OK");
            $finish;
        end
    end

    // ---------------- stimulus and end of run ----------------

    int n_directed;

    initial begin
        // outside a literal: end of text and a stray byte
        push_eot();
        push_byte(CH_X);
        // plain bytes at the edges, a simple escape, a surrogate pair
        push_byte(jsu_pkg::CH_QUOTE);
        push_byte(jsu_pkg::CH_SPACE);
        push_byte(8'hFF);
        push_byte(jsu_pkg::CH_BSLASH);
        push_byte(CH_N);
        push_u(16'hD83D);
        push_u(16'hDE00);
        push_byte(jsu_pkg::CH_QUOTE);
        // control byte, bad escape, early end
        push_byte(jsu_pkg::CH_QUOTE);
        push_byte(8'h1F);
        push_byte(jsu_pkg::CH_QUOTE);
        push_byte(jsu_pkg::CH_BSLASH);
        push_byte(CH_X);
        push_byte(jsu_pkg::CH_QUOTE);
        push_eot();

        n_directed = text_q.size();
        while (text_q.size() < n_directed + RANDOM_ITEMS) push_literal();

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        while (text_q.size() != 0 || s_valid) @(posedge aclk);
        while (utf8_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (err_count == 0) $display("tb OK");
        else $display("tb NOT OK");
        $finish;
    end

endmodule
